// ===== rtl/assert_macros.svh =====
// Assertion macros used by the stack engine controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SME_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack engine assertion failed");

// next-cycle implication, disabled in reset
`define SME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack engine assertion failed");

`endif

// ===== rtl/sme_pkg.sv =====
// Package: types, sizes and codes of the stack engine
`default_nettype none
package sme_pkg;
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = ((CW > 8) ? CW : 8) + 2;

    localparam logic [3:0] REQ_PUSH     = 4'd0;
    localparam logic [3:0] REQ_POP      = 4'd1;
    localparam logic [3:0] REQ_DROP     = 4'd2;
    localparam logic [3:0] REQ_DUP      = 4'd3;
    localparam logic [3:0] REQ_OVER     = 4'd4;
    localparam logic [3:0] REQ_SWAP     = 4'd5;
    localparam logic [3:0] REQ_NIP      = 4'd6;
    localparam logic [3:0] REQ_TUCK     = 4'd7;
    localparam logic [3:0] REQ_ROLLUP   = 4'd8;
    localparam logic [3:0] REQ_ROLLDOWN = 4'd9;
    localparam logic [3:0] REQ_PICK     = 4'd10;
    localparam logic [3:0] REQ_INSERT   = 4'd11;
    localparam logic [3:0] REQ_CLEAR    = 4'd12;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] push_value;
        logic signed [7:0]  position;
        logic [6:0]         amount;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         stack_depth;
        logic [1:0]         status;
    } t_res;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic dec;
        logic hrd;
        logic hcap;
        logic srd;
        logic swr;
        logic fin;
        logic done;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mem_op;
        logic hold_rd;
        logic at_stop;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/sme_datapath.sv =====
// Datapath: word store, depth, decode of a request into a move plan
`default_nettype none
module sme_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sme_pkg::t_req i_req,
    input  wire sme_pkg::t_cmd i_cmd,
    output sme_pkg::t_sts      o_sts,
    output sme_pkg::t_res      o_res
);
    localparam int AW = sme_pkg::AW;
    localparam int CW = sme_pkg::CW;
    localparam int IW = sme_pkg::IW;
    localparam int DW = sme_pkg::DATA_WIDTH;
    localparam int EW = ((CW > 7) ? CW : 7) + 1;

    logic [DW-1:0] r_mem [sme_pkg::DEPTH];
    logic [DW-1:0] r_rdata;
    logic [DW-1:0] r_hold, n_hold;
    sme_pkg::t_req r_req;
    logic [CW-1:0] r_fill, r_nd, n_nd;
    logic [AW-1:0] r_haddr, n_haddr, r_ptr, n_ptr, r_stop, n_stop;
    logic          r_up, n_up, r_fwr, n_fwr, r_rdh, n_rdh, n_hrd, n_mop;
    logic [1:0]    r_st, n_st;

    logic [EW-1:0]        de, ae;
    logic signed [IW-1:0] ds, ps, ts, idx;
    logic                 full;
    logic [AW-1:0]        rd_addr;

    always_comb begin
        de   = EW'(r_fill);
        ae   = EW'(r_req.amount);
        ds   = IW'($signed({1'b0, r_fill}));
        ps   = IW'(r_req.position);
        ts   = ds + ps + IW'(1);
        if (r_req.position < 0) begin
            idx = (ts < 0) ? '0 : ts;
        end else begin
            idx = ps;
        end
        full = (r_fill == CW'(sme_pkg::DEPTH));

        n_hold  = DW'(r_req.push_value);
        n_nd    = r_fill;
        n_st    = sme_pkg::ST_OK;
        n_haddr = AW'(r_fill - CW'(1));
        n_ptr   = AW'(r_fill);
        n_stop  = AW'(r_fill);
        n_up    = 1'b0;
        n_fwr   = 1'b0;
        n_rdh   = 1'b0;
        n_hrd   = 1'b0;
        n_mop   = 1'b0;
        unique case (r_req.req_type)
            sme_pkg::REQ_PUSH: begin
                if (full) n_st = sme_pkg::ST_OVER;
                else begin
                    n_mop = 1'b1; n_fwr = 1'b1; n_nd = r_fill + CW'(1);
                end
            end
            sme_pkg::REQ_POP: begin
                if (r_fill == '0) n_st = sme_pkg::ST_UNDER;
                else begin
                    n_mop = 1'b1; n_hrd = 1'b1; n_rdh = 1'b1; n_nd = r_fill - CW'(1);
                end
            end
            sme_pkg::REQ_DROP: begin
                n_nd = (ae >= de) ? '0 : CW'(de - ae);
            end
            sme_pkg::REQ_DUP, sme_pkg::REQ_OVER: begin
                if (r_fill < ((r_req.req_type == sme_pkg::REQ_DUP) ? CW'(1) : CW'(2)))
                    n_st = sme_pkg::ST_UNDER;
                else if (full) n_st = sme_pkg::ST_OVER;
                else begin
                    n_mop = 1'b1; n_hrd = 1'b1; n_rdh = 1'b1; n_fwr = 1'b1;
                    n_nd = r_fill + CW'(1);
                    if (r_req.req_type == sme_pkg::REQ_OVER)
                        n_haddr = AW'(r_fill - CW'(2));
                end
            end
            sme_pkg::REQ_SWAP: begin
                if (r_fill < CW'(2)) n_st = sme_pkg::ST_UNDER;
                else begin
                    n_mop = 1'b1; n_hrd = 1'b1; n_fwr = 1'b1;
                    n_ptr = AW'(r_fill - CW'(1)); n_stop = AW'(r_fill - CW'(2));
                end
            end
            sme_pkg::REQ_NIP: begin
                if (r_fill < CW'(2)) n_st = sme_pkg::ST_UNDER;
                else begin
                    n_mop = 1'b1; n_hrd = 1'b1; n_fwr = 1'b1;
                    n_ptr = AW'(r_fill - CW'(2)); n_stop = AW'(r_fill - CW'(2));
                    n_nd = r_fill - CW'(1);
                end
            end
            sme_pkg::REQ_TUCK: begin
                if (r_fill < CW'(2)) n_st = sme_pkg::ST_UNDER;
                else if (full) n_st = sme_pkg::ST_OVER;
                else begin
                    n_mop = 1'b1; n_hrd = 1'b1; n_fwr = 1'b1;
                    n_stop = AW'(r_fill - CW'(2)); n_nd = r_fill + CW'(1);
                end
            end
            sme_pkg::REQ_ROLLUP: begin
                if (ae > de) n_st = sme_pkg::ST_UNDER;
                else if (r_req.amount >= 7'd2) begin
                    n_mop = 1'b1; n_hrd = 1'b1; n_fwr = 1'b1;
                    n_ptr = AW'(r_fill - CW'(1)); n_stop = AW'(de - ae);
                end
            end
            sme_pkg::REQ_ROLLDOWN: begin
                if (ae > de) n_st = sme_pkg::ST_UNDER;
                else if (r_req.amount >= 7'd2) begin
                    n_mop = 1'b1; n_hrd = 1'b1; n_fwr = 1'b1; n_up = 1'b1;
                    n_haddr = AW'(de - ae); n_ptr = AW'(de - ae);
                    n_stop = AW'(r_fill - CW'(1));
                end
            end
            sme_pkg::REQ_PICK: begin
                if (idx >= ds) n_st = sme_pkg::ST_RANGE;
                else if (full) n_st = sme_pkg::ST_OVER;
                else begin
                    n_mop = 1'b1; n_hrd = 1'b1; n_rdh = 1'b1; n_fwr = 1'b1;
                    n_haddr = AW'(idx); n_nd = r_fill + CW'(1);
                end
            end
            sme_pkg::REQ_INSERT: begin
                if (idx > ds) n_st = sme_pkg::ST_RANGE;
                else if (full) n_st = sme_pkg::ST_OVER;
                else begin
                    n_mop = 1'b1; n_fwr = 1'b1;
                    n_stop = AW'(idx); n_nd = r_fill + CW'(1);
                end
            end
            sme_pkg::REQ_CLEAR: n_nd = '0;
            default: ;
        endcase
    end

    // read port: hold fetch or shift source
    assign rd_addr = i_cmd.hrd ? r_haddr : (r_up ? r_ptr + AW'(1) : r_ptr - AW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.hrd || i_cmd.srd) r_rdata <= r_mem[rd_addr];
        if (i_cmd.swr)               r_mem[r_ptr]  <= r_rdata;
        else if (i_cmd.fin && r_fwr) r_mem[r_stop] <= r_hold;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_req <= i_req;
        if (i_cmd.dec) begin
            r_hold  <= n_hold;
            r_nd    <= n_nd;
            r_st    <= n_st;
            r_haddr <= n_haddr;
            r_ptr   <= n_ptr;
            r_stop  <= n_stop;
            r_up    <= n_up;
            r_fwr   <= n_fwr;
            r_rdh   <= n_rdh;
        end else begin
            if (i_cmd.hcap) r_hold <= r_rdata;
            if (i_cmd.swr)  r_ptr  <= r_up ? r_ptr + AW'(1) : r_ptr - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.done) begin
            r_fill <= r_nd;
        end
    end

    assign o_sts.mem_op  = n_mop;
    assign o_sts.hold_rd = n_hrd;
    assign o_sts.at_stop = (r_ptr == r_stop);

    // depth shown is the one after the request; r_fill catches up at the strobe edge
    assign o_res.read_value  = r_rdh ? 32'(r_hold) : '0;
    assign o_res.stack_depth = 7'(r_nd);
    assign o_res.status      = r_st;
endmodule
`default_nettype wire

// ===== rtl/sme_ctrl.sv =====
// Controller: sequences decode, hold fetch, shift loop and final write
`default_nettype none
`include "assert_macros.svh"
module sme_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire sme_pkg::t_sts i_sts,
    output sme_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_HRD  = 3'd2;
    localparam logic [2:0] S_HCAP = 3'd3;
    localparam logic [2:0] S_LOOP = 3'd4;
    localparam logic [2:0] S_SWR  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_DEC;
            S_DEC: begin
                if (!i_sts.mem_op)      n_state = S_DONE;
                else if (i_sts.hold_rd) n_state = S_HRD;
                else                    n_state = S_LOOP;
            end
            S_HRD:  n_state = S_HCAP;
            S_HCAP: n_state = S_LOOP;
            S_LOOP: n_state = i_sts.at_stop ? S_FIN : S_SWR;
            S_SWR:  n_state = S_LOOP;
            S_FIN:  n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_start;
    assign o_cmd.dec    = (r_state == S_DEC);
    assign o_cmd.hrd    = (r_state == S_HRD);
    assign o_cmd.hcap   = (r_state == S_HCAP);
    assign o_cmd.srd    = (r_state == S_LOOP) && !i_sts.at_stop;
    assign o_cmd.swr    = (r_state == S_SWR);
    assign o_cmd.fin    = (r_state == S_FIN);
    assign o_cmd.done   = (r_state == S_DONE);

    `SME_ASSERT_NEXT(a_accept_dec, i_clk, i_rst_n, o_cmd.accept, r_state == S_DEC)
    `SME_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_cmd.done, !o_busy)
    `SME_ASSERT_NOW(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.hrd, o_cmd.srd, o_cmd.swr, o_cmd.fin, o_cmd.done}))
endmodule
`default_nettype wire

// ===== rtl/stack_manipulation_engine_core.sv =====
// Top level: fixed-depth data stack engine, controller plus datapath
// Each request is decoded first; drop, clear, unused codes, rolls of under two words and
// any rejected request go straight to the strobe. Others fetch the hold word if needed, shift
// words one place at a time up to the stop address, write the hold word if needed, then strobe.
// One request in flight: busy clears in the cycle after the strobe, when a new request can be accepted.
// Reset (synchronous, active low) empties the stack; store contents are kept.
// The receiver cannot stall: each result is shown for one cycle with o_done.
`default_nettype none
module stack_manipulation_engine_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sme_pkg::t_req i_req,
    output logic               o_done,
    output sme_pkg::t_res      o_res
);
    sme_pkg::t_cmd cmd;
    sme_pkg::t_sts sts;

    // sequencer: decode, hold fetch and capture, shift read and write, final write and done states
    sme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // word store, depth counter and request decode
    sme_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_res)
    );

    assign o_done = cmd.done;
endmodule
`default_nettype wire
